>>> hw/rtl/irp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irp_pkg;

  // Sizes of the pair table and of the chunking.
  localparam int PAIR_ENTRIES = 16;
  localparam int CHUNK_MAX    = 32767;
  localparam int MAX_RESULTS  = 4;

  localparam int IDX_W     = 4;
  localparam int DUR_W     = 16;
  localparam int HALF_W    = 15;
  localparam int LIMIT_W   = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1280;

  localparam int ADDR_W = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;

  // Worst case number of chunks in one half, which is also the worst case
  // number of symbols that one element completes.
  localparam int HALF_CHUNKS_MAX = (65535 + CHUNK_MAX - 1) / CHUNK_MAX;
  localparam int STEP_W = $clog2(HALF_CHUNKS_MAX + 2);
  localparam int TOT_W  = ((STEP_W > LIMIT_W) ? STEP_W : LIMIT_W) + 1;

  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int RIDX_W = $clog2(MAX_RESULTS);

  // One output symbol.
  typedef struct packed {
    logic              lvl_first;
    logic [HALF_W-1:0] dur_first;
    logic              lvl_second;
    logic [HALF_W-1:0] dur_second;
  } sym_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic scan;
    logic decide;
    logic pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic code_failed;
    logic scan_done;
    logic buf_nonempty;
    logic buf_last;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/irp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module irp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire irp_pkg::stat_t stat,
  output irp_pkg::cmd_t      cmd
);
  import irp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshakes and datapath commands.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid && in_mode && !stat.code_failed) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = stat.buf_nonempty;
        if (!stat.buf_nonempty) begin
          state_next = S_IDLE;
        end else if (out_ready) begin
          cmd.pop = 1'b1;
          if (stat.buf_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/irp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module irp_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire irp_pkg::cmd_t               cmd,
  output irp_pkg::stat_t                   stat,
  input  wire logic                        cfg_we,
  input  wire logic [irp_pkg::LIMIT_W-1:0] cfg_data,
  input  wire logic                        in_mode,
  input  wire logic [irp_pkg::IDX_W-1:0]   in_index,
  input  wire logic [irp_pkg::DUR_W-1:0]   in_on,
  input  wire logic [irp_pkg::DUR_W-1:0]   in_off,
  input  wire logic                        in_last,
  output irp_pkg::sym_t                    out_sym,
  output logic                             out_eoc,
  output logic                             out_ovf
);
  import irp_pkg::*;

  localparam logic [DUR_W-1:0] CHUNK_V = DUR_W'(CHUNK_MAX);

  // Pair table: on time in the low half, off time in the high half.
  logic [2*DUR_W-1:0] mem [PAIR_ENTRIES];
  logic [2*DUR_W-1:0] rd_data;

  logic [LIMIT_W-1:0] limit;
  logic               half_pending;
  logic               held_level;
  logic [HALF_W-1:0]  held_duration;
  logic [LIMIT_W-1:0] symbols_emitted;
  logic               code_failed;

  logic               last_r;
  logic               in_range_r;
  logic [DUR_W-1:0]   rem_on;
  logic [DUR_W-1:0]   rem_off;
  logic [STEP_W-1:0]  step_sym;
  sym_t               sbuf [MAX_RESULTS];
  logic [CNT_W-1:0]   count;
  logic [RIDX_W-1:0]  rd_idx;
  logic               ovf_r;

  logic [31:0]        idx_wide;
  logic [ADDR_W-1:0]  addr;
  logic               in_range;
  logic [DUR_W-1:0]   rem_cur;
  logic               cur_level;
  logic [DUR_W-1:0]   chunk;
  logic [TOT_W-1:0]   total;
  logic [TOT_W-1:0]   flush_total;
  logic               room;

  // Table address and range check.
  assign idx_wide = 32'(in_index);
  assign addr     = idx_wide[ADDR_W-1:0];
  assign in_range = idx_wide < 32'(PAIR_ENTRIES);

  // The mark is cut up first, then the space.
  assign cur_level   = (rem_on != '0);
  assign rem_cur     = cur_level ? rem_on : rem_off;
  assign chunk       = (rem_cur > CHUNK_V) ? CHUNK_V : rem_cur;
  assign total       = TOT_W'(symbols_emitted) + TOT_W'(step_sym);
  assign flush_total = total + TOT_W'(half_pending);
  assign room        = count < CNT_W'(MAX_RESULTS);

  // Status for the controller.
  assign stat.code_failed  = code_failed;
  assign stat.scan_done    = (rem_on == '0) && (rem_off == '0);
  assign stat.buf_nonempty = (count != '0);
  assign stat.buf_last     = (CNT_W'(rd_idx) + CNT_W'(1)) == count;

  // Result presented to the output channel.
  assign out_sym = sbuf[rd_idx];
  assign out_eoc = stat.buf_last && (last_r || ovf_r);
  assign out_ovf = ovf_r;

  // Table write and registered table read.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (!in_mode && in_range) begin
        mem[addr] <= {in_off, in_on};
      end
      rd_data <= mem[addr];
    end
  end

  // Per element working registers and result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_idx <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        last_r     <= in_last;
        in_range_r <= in_range;
      end
      if (cmd.load) begin
        rem_on   <= in_range_r ? rd_data[DUR_W-1:0] : '0;
        rem_off  <= in_range_r ? rd_data[2*DUR_W-1:DUR_W] : '0;
        step_sym <= '0;
        count    <= '0;
        rd_idx   <= '0;
        ovf_r    <= 1'b0;
      end
      if (cmd.scan) begin
        if (cur_level) begin
          rem_on <= rem_on - chunk;
        end else begin
          rem_off <= rem_off - chunk;
        end
        if (half_pending) begin
          step_sym <= step_sym + STEP_W'(1);
          if (room) begin
            sbuf[count[RIDX_W-1:0]] <= '{held_level, held_duration, cur_level,
                                         chunk[HALF_W-1:0]};
            count <= count + CNT_W'(1);
          end
        end
      end
      if (cmd.decide) begin
        if (total >= TOT_W'(limit)) begin
          sbuf[0] <= '0;
          count   <= CNT_W'(1);
          ovf_r   <= 1'b1;
        end else if (last_r) begin
          if (flush_total == '0) begin
            sbuf[0] <= '0;
            count   <= CNT_W'(1);
          end else if (half_pending && room) begin
            sbuf[count[RIDX_W-1:0]] <= '{held_level, held_duration, 1'b0, '0};
            count <= count + CNT_W'(1);
          end
        end
      end
      if (cmd.pop) begin
        rd_idx <= rd_idx + RIDX_W'(1);
      end
    end
  end

  // Code state and the symbol limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit           <= LIMIT_RESET;
      half_pending    <= 1'b0;
      held_level      <= 1'b0;
      held_duration   <= '0;
      symbols_emitted <= '0;
      code_failed     <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      // A dropped code ends with its last element.
      if (cmd.capture && in_mode && code_failed && in_last) begin
        half_pending    <= 1'b0;
        held_level      <= 1'b0;
        held_duration   <= '0;
        symbols_emitted <= '0;
        code_failed     <= 1'b0;
      end
      if (cmd.scan) begin
        if (!half_pending) begin
          held_level    <= cur_level;
          held_duration <= chunk[HALF_W-1:0];
          half_pending  <= 1'b1;
        end else begin
          half_pending <= 1'b0;
        end
      end
      if (cmd.decide) begin
        if (last_r) begin
          half_pending    <= 1'b0;
          held_level      <= 1'b0;
          held_duration   <= '0;
          symbols_emitted <= '0;
          code_failed     <= 1'b0;
        end else if (total >= TOT_W'(limit)) begin
          code_failed <= 1'b1;
        end else begin
          symbols_emitted <= total[LIMIT_W-1:0];
        end
      end
    end
  end

  // The buffer never holds more than its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond buffer capacity");

  // An overflow report is always a single result.
  a_ovf_single: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && (total >= TOT_W'(limit)) |=> ovf_r && (count == CNT_W'(1)))
    else $error("overflow report is not a single result");

  // The end of a code leaves nothing pending.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && last_r |=> !half_pending && (symbols_emitted == '0))
    else $error("code state not cleared at end of code");

endmodule

`default_nettype wire

>>> hw/rtl/ir_pulse_to_symbol_packer.sv
// Each sequence element is cut into H chunks (0 to 6) of its pair, one chunk
// per cycle in the scan loop, before its first result; results then leave
// one per cycle while out_ready is high. A new element or table write is
// taken only in the idle state, so an element is not taken before the last
// one's results have all left. Synchronous active-high reset clears the code
// state and sets symbol_limit to 1280; the pair table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_to_symbol_packer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [irp_pkg::LIMIT_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        mode,
  input  wire logic [irp_pkg::IDX_W-1:0]   pair_index,
  input  wire logic [irp_pkg::DUR_W-1:0]   on_duration,
  input  wire logic [irp_pkg::DUR_W-1:0]   off_duration,
  input  wire logic                        last_pair,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             level_first,
  output logic [irp_pkg::HALF_W-1:0]       duration_first,
  output logic                             level_second,
  output logic [irp_pkg::HALF_W-1:0]       duration_second,
  output logic                             end_of_code,
  output logic                             overflow
);
  import irp_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  sym_t  sym;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  irp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  irp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_mode  (mode),
    .in_index (pair_index),
    .in_on    (on_duration),
    .in_off   (off_duration),
    .in_last  (last_pair),
    .out_sym  (sym),
    .out_eoc  (end_of_code),
    .out_ovf  (overflow)
  );

  // Result fields.
  assign level_first     = sym.lvl_first;
  assign duration_first  = sym.dur_first;
  assign level_second    = sym.lvl_second;
  assign duration_second = sym.dur_second;

endmodule

`default_nettype wire
